// ----- hw/rtl/shfp_pkg.sv -----
// Shared types and constants for the sync-header frame parser.
// Used by shfp_core and sync_header_frame_parser; depends on nothing else.
`timescale 1ns / 1ps

package shfp_pkg;

  localparam logic [7:0] SYNC_BYTE        = 8'hAA;
  localparam logic [7:0] KIND_CTRL_BYTE   = 8'hAA;
  localparam logic [7:0] KIND_SENSOR_BYTE = 8'hCC;

  localparam int unsigned PAYLOAD_LEN = 12;
  localparam int unsigned NUM_WORDS   = PAYLOAD_LEN / 2;
  localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);
  localparam int unsigned CNT_W       = 32;

  localparam logic [IDX_W-1:0] PAYLOAD_LEN_IDX = IDX_W'(PAYLOAD_LEN);

  typedef struct packed {
    logic                        frame_kind;
    logic [NUM_WORDS-1:0][15:0]  words;
    logic [CNT_W-1:0]            control_frames;
    logic [CNT_W-1:0]            sensor_frames;
    logic [CNT_W-1:0]            bytes_seen;
  } result_t;

endpackage

// ----- hw/rtl/shfp_core.sv -----
// Parse state machine, payload store, checksum and counters of the frame parser.
// Depends on shfp_pkg.
`timescale 1ns / 1ps

module shfp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output logic                produce_o,
  output shfp_pkg::result_t   result_o
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_KIND    = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_CHECK   = 2'd3;

  logic [1:0]                   phase_q, phase_d;
  logic                         kind_q, kind_d;
  logic [shfp_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [7:0]                   xor_q, xor_d;
  logic [shfp_pkg::CNT_W-1:0]   ctrl_cnt_q, ctrl_cnt_d;
  logic [shfp_pkg::CNT_W-1:0]   sens_cnt_q, sens_cnt_d;
  logic [shfp_pkg::CNT_W-1:0]   byte_cnt_q, byte_cnt_d;
  logic [7:0]                   payload_q [shfp_pkg::PAYLOAD_LEN];

  logic                         good;
  logic                         payload_wr;
  logic [shfp_pkg::IDX_W-1:0]   idx_inc;
  logic [shfp_pkg::CNT_W-1:0]   ctrl_inc, sens_inc;

  assign good       = (phase_q == PH_CHECK) && (byte_i == xor_q);
  assign produce_o  = good;
  assign payload_wr = step_i && (phase_q == PH_PAYLOAD) && (idx_q < shfp_pkg::PAYLOAD_LEN_IDX);
  assign idx_inc    = idx_q + shfp_pkg::IDX_W'(1);
  assign ctrl_inc   = ctrl_cnt_q + shfp_pkg::CNT_W'(1);
  assign sens_inc   = sens_cnt_q + shfp_pkg::CNT_W'(1);
  assign byte_cnt_d = byte_cnt_q + shfp_pkg::CNT_W'(1);

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    idx_d      = idx_q;
    xor_d      = xor_q;
    ctrl_cnt_d = ctrl_cnt_q;
    sens_cnt_d = sens_cnt_q;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == shfp_pkg::SYNC_BYTE) phase_d = PH_KIND;
      end
      PH_KIND: begin
        if (byte_i inside {shfp_pkg::KIND_CTRL_BYTE, shfp_pkg::KIND_SENSOR_BYTE}) begin
          kind_d  = (byte_i == shfp_pkg::KIND_SENSOR_BYTE);
          idx_d   = '0;
          xor_d   = '0;
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (idx_q < shfp_pkg::PAYLOAD_LEN_IDX) begin
          xor_d = xor_q ^ byte_i;
          idx_d = idx_inc;
          if (idx_inc >= shfp_pkg::PAYLOAD_LEN_IDX) phase_d = PH_CHECK;
        end else begin
          phase_d = PH_CHECK;
        end
      end
      default: begin
        if (good) begin
          if (kind_q) sens_cnt_d = sens_inc;
          else        ctrl_cnt_d = ctrl_inc;
        end
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      kind_q     <= 1'b0;
      idx_q      <= '0;
      xor_q      <= '0;
      ctrl_cnt_q <= '0;
      sens_cnt_q <= '0;
      byte_cnt_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      kind_q     <= kind_d;
      idx_q      <= idx_d;
      xor_q      <= xor_d;
      ctrl_cnt_q <= ctrl_cnt_d;
      sens_cnt_q <= sens_cnt_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (payload_wr) payload_q[idx_q] <= byte_i;
  end

  always_comb begin
    result_o.frame_kind     = kind_q;
    result_o.control_frames = kind_q ? ctrl_cnt_q : ctrl_inc;
    result_o.sensor_frames  = kind_q ? sens_inc : sens_cnt_q;
    result_o.bytes_seen     = byte_cnt_d;
    for (int k = 0; k < shfp_pkg::NUM_WORDS; k++) begin
      result_o.words[k] = {payload_q[2*k], payload_q[2*k+1]};
    end
  end

endmodule

// ----- hw/rtl/sync_header_frame_parser.sv -----
// Top level of the sync-header frame parser: input register, output register, handshakes.
// Depends on shfp_pkg and shfp_core.
`timescale 1ns / 1ps

// The block takes one received byte per item on the input channel (in_valid_i, in_ready_o,
// rx_byte_i). It hunts for the sync byte 0xAA, takes the next byte as the frame kind (0xAA
// for a control frame, 0xCC for a sensor frame), gathers twelve payload bytes with their
// running XOR and compares the checksum byte against it.
// A good frame produces one item on the output channel (out_valid_o, out_ready_i): the kind,
// six big-endian 16-bit words and the wrapping frame and byte counts. A bad checksum or a
// byte that is not part of a good frame's end produces nothing.
// An accepted byte is held in the input register and processed from there; a result is
// then loaded into the output register and offered, but waits while the output register
// still holds an earlier item that the receiver has not taken.
// Throughput is one byte per cycle unless a result waits on the output register: the whole
// parse step is a single compare, XOR and 32-bit increment between the input and output registers.
// When the receiver stalls, the output register holds its item. Bytes that produce no
// result still flow through; the input register only waits when its byte would produce a
// result while the output register is still full, and the stall then reaches in_ready_o.
// Reset clears the parse phase, the checksum, all counters and both valid flags; the
// payload bytes are not reset since they are always written before they are read.

module sync_header_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_kind_o,
  output logic [15:0] word_0_o,
  output logic [15:0] word_1_o,
  output logic [15:0] word_2_o,
  output logic [15:0] word_3_o,
  output logic [15:0] word_4_o,
  output logic [15:0] word_5_o,
  output logic [31:0] control_frames_o,
  output logic [31:0] sensor_frames_o,
  output logic [31:0] bytes_seen_o
);

  // Input register.
  logic              in_vld_q;
  logic [7:0]        in_byte_q;

  // Output register.
  logic              out_vld_q;
  shfp_pkg::result_t out_q;

  logic              produce;
  logic              out_free;
  logic              advance;
  shfp_pkg::result_t result;

  // The byte in the input register moves on unless it needs the output register and that
  // register still holds an item the receiver has not taken.
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && (!produce || out_free);
  assign in_ready_o = !in_vld_q || advance;

  shfp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .produce_o (produce),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance && produce) out_vld_q <= 1'b1;
      else if (out_ready_i)   out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_byte_q <= rx_byte_i;
    if (advance && produce)       out_q     <= result;
  end

  assign out_valid_o      = out_vld_q;
  assign frame_kind_o     = out_q.frame_kind;
  assign word_0_o         = out_q.words[0];
  assign word_1_o         = out_q.words[1];
  assign word_2_o         = out_q.words[2];
  assign word_3_o         = out_q.words[3];
  assign word_4_o         = out_q.words[4];
  assign word_5_o         = out_q.words[5];
  assign control_frames_o = out_q.control_frames;
  assign sensor_frames_o  = out_q.sensor_frames;
  assign bytes_seen_o     = out_q.bytes_seen;

endmodule

// ----- hw/rtl/shfp_checker.sv -----
// Port-level checks for the sync-header frame parser, bound to its top level.
// Depends on sync_header_frame_parser.
`timescale 1ns / 1ps

module shfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        frame_kind_o,
  input logic [15:0] word_0_o,
  input logic [31:0] control_frames_o,
  input logic [31:0] sensor_frames_o,
  input logic [31:0] bytes_seen_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its first word and its byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(word_0_o) && $stable(bytes_seen_o))
    else $error("result payload changed while stalled");

  // A good frame is counted in its own kind's counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_kind_o ? (sensor_frames_o != 32'd0)
                                  : (control_frames_o != 32'd0)))
    else $error("frame counter of reported kind is zero");

  // The shortest good frame is fifteen bytes long.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bytes_seen_o >= 32'd15)
    else $error("result after too few bytes");

endmodule

bind sync_header_frame_parser shfp_checker u_shfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .frame_kind_o     (frame_kind_o),
  .word_0_o         (word_0_o),
  .control_frames_o (control_frames_o),
  .sensor_frames_o  (sensor_frames_o),
  .bytes_seen_o     (bytes_seen_o)
);
